### design/mbe_pkg.sv
// Types, constants and the gradient palette table of the escape-time pixel core.
// No dependencies; every other file imports this package.
package mbe_pkg;

   localparam int FRAC_BITS  = 28;
   localparam int Q_W        = 36;
   localparam int MAG_W      = 36;
   localparam int HALF_W     = 18;
   localparam int PROD_W     = 72;
   localparam int SQ_W       = 43;
   localparam int FIN_W      = 46;
   localparam int SUM_W      = 47;
   localparam int PIX_W      = 12;
   localparam int DIM_W      = 13;
   localparam int MAXIT_W    = 16;
   localparam int COUNT_W    = 17;
   localparam int CENTER_W   = 32;
   localparam int VIEW_W     = 31;
   localparam int DIVD_W     = VIEW_W + PIX_W;
   localparam int MAP_W      = 45;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int RGB_W      = 24;
   localparam int PAL_N      = 256;
   localparam int PAL_IDX_W  = 8;

   localparam logic signed [SUM_W-1:0] Q_MAX_EXT = SUM_W'((64'sd1 <<< (Q_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] Q_MIN_EXT = SUM_W'(-(64'sd1 <<< (Q_W - 1)));
   localparam logic [SQ_W:0]           ESCAPE_LIMIT = (SQ_W + 1)'(64'd4 << FRAC_BITS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_MAX_ITER     = 3'd2,
      CSR_CENTER_REAL  = 3'd3,
      CSR_CENTER_IMAG  = 3'd4,
      CSR_VIEW_SIZE    = 3'd5
   } csr_index_type;

   typedef logic signed [Q_W-1:0] q_type;

   typedef struct packed {
      logic [DIM_W-1:0]           image_width;
      logic [DIM_W-1:0]           image_height;
      logic signed [CENTER_W-1:0] center_real;
      logic signed [CENTER_W-1:0] center_imag;
      logic [VIEW_W-1:0]          view_size;
   } map_cfg_type;

   typedef struct packed {
      q_type c_real;
      q_type c_imag;
   } point_type;

   typedef enum logic [2:0] {
      FR_IDLE, FR_MUL, FR_DIV, FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_MUL_LO, BK_MUL_HI, BK_FIN, BK_SUM, BK_DONE
   } back_state_type;

   function automatic q_type sat_q(logic signed [SUM_W-1:0] v);
      if (v > Q_MAX_EXT) return Q_MAX_EXT[Q_W-1:0];
      if (v < Q_MIN_EXT) return Q_MIN_EXT[Q_W-1:0];
      return v[Q_W-1:0];
   endfunction

   // floor(+/-p / 2^shift): the sign is applied before rounding down; shift is FRAC_BITS or FRAC_BITS-1
   function automatic logic signed [FIN_W-1:0] mul_finish(logic [PROD_W-1:0] p, logic neg,
                                                          logic dbl);
      logic [FIN_W-1:0] q;
      logic             rem;
      if (dbl) begin
         q   = FIN_W'(p[PROD_W-1:FRAC_BITS-1]);
         rem = |p[FRAC_BITS-2:0];
      end else begin
         q   = FIN_W'(p[PROD_W-1:FRAC_BITS]);
         rem = |p[FRAC_BITS-1:0];
      end
      q = q + FIN_W'(neg & rem);
      return neg ? -$signed(q) : $signed(q);
   endfunction

   localparam int ANCHOR_POS[6] = '{0, 160, 420, 642, 800, 1000};
   localparam int ANCHOR_R[6]   = '{0, 32, 237, 255, 0, 0};
   localparam int ANCHOR_G[6]   = '{7, 107, 255, 170, 2, 7};
   localparam int ANCHOR_B[6]   = '{100, 203, 255, 0, 0, 100};
   localparam int SEG_DEN_0 = 160 * 255;
   localparam int SEG_DEN_1 = 260 * 255;
   localparam int SEG_DEN_2 = 222 * 255;
   localparam int SEG_DEN_3 = 158 * 255;
   localparam int SEG_DEN_4 = 200 * 255;

   function automatic int seg_den(int p);
      unique case (p)
         0: return SEG_DEN_0;
         1: return SEG_DEN_1;
         2: return SEG_DEN_2;
         3: return SEG_DEN_3;
         default: return SEG_DEN_4;
      endcase
   endfunction

   function automatic int seg_div(int p, int t);
      unique case (p)
         0: return t / SEG_DEN_0;
         1: return t / SEG_DEN_1;
         2: return t / SEG_DEN_2;
         3: return t / SEG_DEN_3;
         default: return t / SEG_DEN_4;
      endcase
   endfunction

   function automatic int lerp(int p, int num, int c0, int c1);
      int v;
      v = seg_div(p, c0 * seg_den(p) + num * (c1 - c0));
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v;
   endfunction

   function automatic logic [PAL_N-1:0][RGB_W-1:0] build_palette();
      logic [PAL_N-1:0][RGB_W-1:0] pal;
      int p;
      int num;
      for (int i = 0; i < PAL_N; i++) begin
         p = 0;
         for (int k = 0; k < 4; k++)
            if (p == k && i * 1000 > ANCHOR_POS[k + 1] * (PAL_N - 1)) p = k + 1;
         num = i * 1000 - ANCHOR_POS[p] * (PAL_N - 1);
         pal[i] = {8'(lerp(p, num, ANCHOR_R[p], ANCHOR_R[p + 1])),
                   8'(lerp(p, num, ANCHOR_G[p], ANCHOR_G[p + 1])),
                   8'(lerp(p, num, ANCHOR_B[p], ANCHOR_B[p + 1]))};
      end
      return pal;
   endfunction

   localparam logic [PAL_N-1:0][RGB_W-1:0] PALETTE = build_palette();

endpackage

### design/mbe_ifs.sv
// Valid/ready channel interfaces: pixel requests, mapped points, pixel results.
// Depends on mbe_pkg.
interface mbe_req_if import mbe_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_x;
   logic [PIX_W-1:0] pixel_y;
   modport source (output valid, pixel_x, pixel_y, input ready);
   modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface mbe_pt_if import mbe_pkg::*; ();
   logic      valid;
   logic      ready;
   point_type point;
   modport source (output valid, point, input ready);
   modport sink (input valid, point, output ready);
endinterface

interface mbe_rsp_if import mbe_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] iteration_count;
   logic [7:0]         red;
   logic [7:0]         green;
   logic [7:0]         blue;
   modport source (output valid, iteration_count, red, green, blue, input ready);
   modport sink (input valid, iteration_count, red, green, blue, output ready);
endinterface

### design/mbe_div.sv
// Restoring divider, one quotient bit per cycle, for the coordinate scaling.
// Depends on mbe_pkg.
module mbe_div import mbe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIM_W-1:0]  divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIM_W-1:0]  rem_ff, rem_in, dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DIM_W:0]    trial, diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      ge      = trial >= {1'b0, dsr_ff};
      diff    = trial - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVD_W-2:0], ge};
         rem_in = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

### design/mbe_front.sv
// Front end: accepts pixel requests and maps them to points of the complex plane.
// Depends on mbe_pkg, mbe_ifs and mbe_div.
module mbe_front import mbe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  map_cfg_type cfg,
   mbe_req_if.sink     req,
   mbe_pt_if.source    pt
);
   front_state_type   state_ff, state_in;
   logic [PIX_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic              sel_ff, sel_in;
   q_type             cr_ff, cr_in, ci_ff, ci_in;
   logic              div_start, div_done;
   logic [DIVD_W-1:0] quot, prod;
   logic [DIM_W-1:0]  span, divisor;
   logic signed [CENTER_W-1:0] center;
   logic signed [MAP_W-1:0]    mapped;
   q_type             c_sat;

   always_comb begin
      span    = sel_ff ? cfg.image_height : cfg.image_width;
      divisor = (span == '0) ? DIM_W'(1) : span;
      prod    = DIVD_W'(cfg.view_size) * DIVD_W'(sel_ff ? py_ff : px_ff);
      center  = sel_ff ? cfg.center_imag : cfg.center_real;
      mapped  = MAP_W'(center) - $signed(MAP_W'(cfg.view_size >> 1))
                + $signed(MAP_W'(quot));
      c_sat   = sat_q(SUM_W'(mapped));
   end

   mbe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      state_in  = state_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      sel_in    = sel_ff;
      cr_in     = cr_ff;
      ci_in     = ci_ff;
      div_start = 1'b0;
      req.ready = 1'b0;
      pt.valid  = 1'b0;
      unique case (state_ff)
         FR_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               px_in    = req.pixel_x;
               py_in    = req.pixel_y;
               sel_in   = 1'b0;
               state_in = FR_MUL;
            end
         end
         FR_MUL: begin
            div_start = 1'b1;
            state_in  = FR_DIV;
         end
         FR_DIV: begin
            if (div_done) begin
               if (sel_ff) begin
                  ci_in    = c_sat;
                  state_in = FR_PUSH;
               end else begin
                  cr_in    = c_sat;
                  sel_in   = 1'b1;
                  state_in = FR_MUL;
               end
            end
         end
         FR_PUSH: begin
            pt.valid = 1'b1;
            if (pt.ready) state_in = FR_IDLE;
         end
         default: state_in = FR_IDLE;
      endcase
   end

   assign pt.point = '{c_real: cr_ff, c_imag: ci_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      px_ff  <= px_in;
      py_ff  <= py_in;
      sel_ff <= sel_in;
      cr_ff  <= cr_in;
      ci_ff  <= ci_in;
   end
endmodule

### design/mbe_queue.sv
// Small FIFO of mapped points between the front end and the iteration engine.
// Depends on mbe_pkg and mbe_ifs.
module mbe_queue import mbe_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   mbe_pt_if.sink   wr,
   mbe_pt_if.source rd
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   point_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   always_comb begin
      wr.ready = cnt_ff != CNT_W'(DEPTH);
      rd.valid = cnt_ff != '0;
      rd.point = mem_ff[rp_ff];
      push     = wr.valid && wr.ready;
      pop      = rd.valid && rd.ready;
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      if (push) wp_in = (wp_ff == PTR_W'(DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
      if (pop) rp_in = (rp_ff == PTR_W'(DEPTH - 1)) ? '0 : rp_ff + PTR_W'(1);
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= wr.point;
   end
endmodule

### design/mbe_back.sv
// Iteration engine: runs z = z^2 + c on split multipliers, colors the count.
// Depends on mbe_pkg and mbe_ifs.
module mbe_back import mbe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [MAXIT_W-1:0] max_iterations,
   mbe_pt_if.sink             pt,
   mbe_rsp_if.source          rsp
);
   back_state_type     state_ff, state_in;
   q_type              cr_ff, cr_in, ci_ff, ci_in, zr_ff, zr_in, zi_ff, zi_in;
   logic [SQ_W-1:0]    rr_ff, rr_in, ii_ff, ii_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [PROD_W-1:0]  arr_ff, arr_in, aii_ff, aii_in, azz_ff, azz_in;
   logic signed [FIN_W-1:0] prr_ff, prr_in, pii_ff, pii_in, pzz_ff, pzz_in;
   logic               neg_ff, neg_in;
   logic               ov_ff, ov_in;
   logic [COUNT_W-1:0] oc_ff, oc_in;
   logic [RGB_W-1:0]   orgb_ff, orgb_in;
   logic [MAG_W-1:0]   mzr, mzi;
   logic [HALF_W-1:0]  hzr, hzi;
   logic [MAG_W+HALF_W-1:0] mrr, mii, mzz;
   logic               slot, brk;
   logic [COUNT_W-1:0] max_ext;

   always_comb begin
      mzr     = zr_ff[Q_W-1] ? MAG_W'(-zr_ff) : MAG_W'(zr_ff);
      mzi     = zi_ff[Q_W-1] ? MAG_W'(-zi_ff) : MAG_W'(zi_ff);
      hzr     = (state_ff == BK_MUL_HI) ? mzr[MAG_W-1:HALF_W] : mzr[HALF_W-1:0];
      hzi     = (state_ff == BK_MUL_HI) ? mzi[MAG_W-1:HALF_W] : mzi[HALF_W-1:0];
      mrr     = mzr * hzr;
      mii     = mzi * hzi;
      mzz     = mzr * hzi;
      max_ext = COUNT_W'(max_iterations);
      slot    = !ov_ff || rsp.ready;
      brk     = (n_ff >= max_ext) || (({1'b0, rr_ff} + {1'b0, ii_ff}) >= ESCAPE_LIMIT);
   end

   always_comb begin
      state_in = state_ff;
      cr_in = cr_ff; ci_in = ci_ff; zr_in = zr_ff; zi_in = zi_ff;
      rr_in = rr_ff; ii_in = ii_ff; n_in = n_ff;
      arr_in = arr_ff; aii_in = aii_ff; azz_in = azz_ff;
      prr_in = prr_ff; pii_in = pii_ff; pzz_in = pzz_ff;
      neg_in = neg_ff;
      ov_in   = ov_ff && !rsp.ready;
      oc_in   = oc_ff;
      orgb_in = orgb_ff;
      pt.ready = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pt.ready = 1'b1;
            if (pt.valid) begin
               cr_in = pt.point.c_real;
               ci_in = pt.point.c_imag;
               zr_in = '0; zi_in = '0; rr_in = '0; ii_in = '0; n_in = '0;
               state_in = BK_MUL_LO;
            end
         end
         BK_MUL_LO: begin
            n_in = n_ff + COUNT_W'(1);
            if (brk) begin
               state_in = BK_DONE;
            end else begin
               arr_in   = PROD_W'(mrr);
               aii_in   = PROD_W'(mii);
               azz_in   = PROD_W'(mzz);
               neg_in   = zr_ff[Q_W-1] != zi_ff[Q_W-1];
               state_in = BK_MUL_HI;
            end
         end
         BK_MUL_HI: begin
            arr_in   = arr_ff + (PROD_W'(mrr) << HALF_W);
            aii_in   = aii_ff + (PROD_W'(mii) << HALF_W);
            azz_in   = azz_ff + (PROD_W'(mzz) << HALF_W);
            state_in = BK_FIN;
         end
         BK_FIN: begin
            prr_in   = mul_finish(arr_ff, 1'b0, 1'b0);
            pii_in   = mul_finish(aii_ff, 1'b0, 1'b0);
            pzz_in   = mul_finish(azz_ff, neg_ff, 1'b1);
            state_in = BK_SUM;
         end
         BK_SUM: begin
            rr_in    = prr_ff[SQ_W-1:0];
            ii_in    = pii_ff[SQ_W-1:0];
            zi_in    = sat_q(SUM_W'(pzz_ff) + SUM_W'(ci_ff));
            zr_in    = sat_q(SUM_W'(prr_ff) - SUM_W'(pii_ff) + SUM_W'(cr_ff));
            state_in = BK_MUL_LO;
         end
         BK_DONE: begin
            if (slot) begin
               ov_in    = 1'b1;
               oc_in    = n_ff;
               orgb_in  = (n_ff < max_ext) ? PALETTE[n_ff[PAL_IDX_W-1:0]] : '0;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign rsp.valid           = ov_ff;
   assign rsp.iteration_count = oc_ff;
   assign rsp.red             = orgb_ff[23:16];
   assign rsp.green           = orgb_ff[15:8];
   assign rsp.blue            = orgb_ff[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
      cr_ff <= cr_in; ci_ff <= ci_in; zr_ff <= zr_in; zi_ff <= zi_in;
      rr_ff <= rr_in; ii_ff <= ii_in; n_ff <= n_in;
      arr_ff <= arr_in; aii_ff <= aii_in; azz_ff <= azz_in;
      prr_ff <= prr_in; pii_ff <= pii_in; pzz_ff <= pzz_in;
      neg_ff <= neg_in; oc_ff <= oc_in; orgb_ff <= orgb_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_MUL_LO |-> n_ff <= max_ext)
      else $error("iteration counter ran past the limit");

   a_black_at_limit: assert property (@(posedge clock) disable iff (reset)
      ov_ff && oc_ff >= max_ext |-> orgb_ff == '0)
      else $error("pixel at the limit is not black");

   a_result_count: assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> oc_ff != '0 && oc_ff <= max_ext + COUNT_W'(1))
      else $error("result count out of range");
endmodule

### design/mandelbrot_escape_time_pixel_core.sv
// Top level of the escape-time pixel core: register file, front end, queue, engine.
// Depends on mbe_pkg, mbe_ifs, mbe_front, mbe_queue and mbe_back.
//
//   channel  | dir | handshake      | payload
//   req_if   | in  | valid/ready    | pixel_x[11:0], pixel_y[11:0]
//   rsp_if   | out | valid/ready    | iteration_count[16:0], red, green, blue
//   csr_*    | in  | csr_wr_en      | csr_index[2:0], csr_wdata[31:0]
//
// Mapping runs two passes of the bit-serial divider per pixel, real axis then imaginary.
// Each update steps through MUL_LO, MUL_HI, FIN and SUM on split 36x18 multipliers.
// Front end and engine overlap through a QUEUE_DEPTH-entry point queue.
// Synchronous active-high reset restores the register defaults; no clearing pass.
// A held result stalls only the engine's final write; requests flow until the queue fills.
module mandelbrot_escape_time_pixel_core import mbe_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   mbe_req_if.sink               req_if,
   mbe_rsp_if.source             rsp_if,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   map_cfg_type        cfg_ff, cfg_in;
   logic [MAXIT_W-1:0] maxit_ff, maxit_in;

   always_comb begin
      cfg_in   = cfg_ff;
      maxit_in = maxit_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[DIM_W-1:0];
            CSR_MAX_ITER:     maxit_in            = csr_wdata[MAXIT_W-1:0];
            CSR_CENTER_REAL:  cfg_in.center_real  = $signed(csr_wdata);
            CSR_CENTER_IMAG:  cfg_in.center_imag  = $signed(csr_wdata);
            CSR_VIEW_SIZE:    cfg_in.view_size    = csr_wdata[VIEW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= DIM_W'(640);
         cfg_ff.image_height <= DIM_W'(480);
         cfg_ff.center_real  <= 32'shF400_0000;
         cfg_ff.center_imag  <= '0;
         cfg_ff.view_size    <= VIEW_W'(805306368);
         maxit_ff            <= MAXIT_W'(256);
      end else begin
         cfg_ff   <= cfg_in;
         maxit_ff <= maxit_in;
      end
   end

   mbe_pt_if pt_wr ();
   mbe_pt_if pt_rd ();

   mbe_front u_front (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (req_if),
      .pt    (pt_wr)
   );

   mbe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (pt_wr),
      .rd    (pt_rd)
   );

   mbe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .max_iterations (maxit_ff),
      .pt             (pt_rd),
      .rsp            (rsp_if)
   );
endmodule

### verif/tb.sv
// Self-checking testbench of mandelbrot_escape_time_pixel_core: directed and random pixels
// against an in-bench fixed-point predictor. Depends on mbe_pkg, mbe_ifs and the core.
module tb import mbe_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;
   localparam longint WIDE_CLAMP = 64'sd1 <<< 50;
   localparam longint QV_MAX = (64'sd1 <<< 35) - 1;
   localparam longint QV_MIN = -(64'sd1 <<< 35);

   typedef struct packed {
      logic [COUNT_W-1:0] iteration_count;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } pixel_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   mbe_req_if req_if ();
   mbe_rsp_if rsp_if ();

   mandelbrot_escape_time_pixel_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6ns clock = ~clock;

   // view state mirrored from the register writes
   int unsigned view_width, view_height, iter_limit, view_span;
   longint view_cre, view_cim;
   logic [RGB_W-1:0] color_ramp [PAL_N];

   pixel_result_t expected_pixels [$];
   int error_count = 0;
   int pixels_sent = 0;
   int pixels_seen = 0;
   int dark_pixels = 0;
   int send_idle = 0;
   int recv_idle = 0;

   function automatic void build_color_ramp();
      int pos [6] = '{0, 160, 420, 642, 800, 1000};
      int rgb [6][3] = '{'{0, 7, 100}, '{32, 107, 203}, '{237, 255, 255},
                         '{255, 170, 0}, '{0, 2, 0}, '{0, 7, 100}};
      int p, num, den, v;
      for (int i = 0; i < PAL_N; i++) begin
         p = 0;
         while (p < 4 && i * 1000 > pos[p + 1] * (PAL_N - 1)) p++;
         num = i * 1000 - pos[p] * (PAL_N - 1);
         den = (pos[p + 1] - pos[p]) * (PAL_N - 1);
         for (int ch = 0; ch < 3; ch++) begin
            v = (rgb[p][ch] * den + num * (rgb[p + 1][ch] - rgb[p][ch])) / den;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            color_ramp[i][23 - 8 * ch -: 8] = 8'(v);
         end
      end
   endfunction

   function automatic longint sat_point(longint v);
      if (v > QV_MAX) return QV_MAX;
      if (v < QV_MIN) return QV_MIN;
      return v;
   endfunction

   function automatic longint scaled_mul(longint a, longint b, int sh);
      logic signed [127:0] pa, pb, pr;
      pa = a;
      pb = b;
      pr = (pa * pb) >>> sh;
      if (pr > WIDE_CLAMP) return WIDE_CLAMP;
      if (pr < -WIDE_CLAMP) return -WIDE_CLAMP;
      return longint'(pr);
   endfunction

   function automatic longint map_axis(longint center, int unsigned pix, int unsigned span);
      longint sq, d;
      sq = longint'(view_span);
      d = (span == 0) ? 1 : longint'(span);
      return sat_point(center - sq / 2 + (sq * longint'(pix)) / d);
   endfunction

   function automatic pixel_result_t predict_pixel(int unsigned px, int unsigned py);
      pixel_result_t res;
      longint cr, ci, zr, zi, rr, ii;
      int unsigned n;
      cr = map_axis(view_cre, px, view_width);
      ci = map_axis(view_cim, py, view_height);
      zr = 0; zi = 0; rr = 0; ii = 0;
      n = 0;
      forever begin
         bit go;
         go = n < iter_limit;
         n++;
         if (!go || rr + ii >= (64'sd4 <<< FRAC_BITS)) break;
         rr = scaled_mul(zr, zr, FRAC_BITS);
         ii = scaled_mul(zi, zi, FRAC_BITS);
         zi = sat_point(scaled_mul(zr, zi, FRAC_BITS - 1) + ci);
         zr = sat_point(rr - ii + cr);
      end
      res.iteration_count = COUNT_W'(n);
      {res.red, res.green, res.blue} = (n < iter_limit) ? color_ramp[n % PAL_N] : '0;
      return res;
   endfunction

   // result side: random backpressure and in-order checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
               $error("unexpected result count=%0d", rsp_if.iteration_count);
               error_count++;
            end else begin
               pixel_result_t e;
               e = expected_pixels.pop_front();
               if (e.iteration_count > iter_limit) dark_pixels++;
               if (rsp_if.iteration_count !== e.iteration_count) begin
                  $error("iteration_count exp %0d got %0d", e.iteration_count,
                         rsp_if.iteration_count);
                  error_count++;
               end
               if (rsp_if.red !== e.red) begin
                  $error("red exp %0d got %0d", e.red, rsp_if.red);
                  error_count++;
               end
               if (rsp_if.green !== e.green) begin
                  $error("green exp %0d got %0d", e.green, rsp_if.green);
                  error_count++;
               end
               if (rsp_if.blue !== e.blue) begin
                  $error("blue exp %0d got %0d", e.blue, rsp_if.blue);
                  error_count++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_pixel(int unsigned px, int unsigned py);
      if ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_if.valid   <= 1'b1;
      req_if.pixel_x <= PIX_W'(px);
      req_if.pixel_y <= PIX_W'(py);
      do @(posedge clock); while (!req_if.ready);
      expected_pixels.push_back(predict_pixel(px & 12'hfff, py & 12'hfff));
      pixels_sent++;
   endtask

   task automatic drain_pixels();
      req_if.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_view(int unsigned w, int unsigned h, int unsigned m,
                             longint cre, longint cim, int unsigned vs);
      logic [CSR_DATA_W-1:0] vals [6];
      csr_index_type idx [6] = '{CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT, CSR_MAX_ITER,
                                 CSR_CENTER_REAL, CSR_CENTER_IMAG, CSR_VIEW_SIZE};
      drain_pixels();
      vals = '{w, h, m, 32'(cre), 32'(cim), vs};
      for (int k = 0; k < 6; k++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= vals[k];
         @(posedge clock);
      end
      csr_index <= CSR_SPARE_6;
      csr_wdata <= $urandom();
      @(posedge clock);
      csr_index <= CSR_SPARE_7;
      csr_wdata <= $urandom();
      @(posedge clock);
      csr_wr_en <= 1'b0;
      view_width  = w & 13'h1fff;
      view_height = h & 13'h1fff;
      iter_limit  = m & 16'hffff;
      view_cre    = longint'($signed(32'(cre)));
      view_cim    = longint'($signed(32'(cim)));
      view_span   = vs & 31'h7fffffff;
   endtask

   task automatic test_reset_view();
      send_pixel(0, 0);
      send_pixel(639, 479);
      send_pixel(320, 240);
      send_pixel(100, 200);
      send_pixel(4095, 4095);
   endtask

   task automatic test_edge_views();
      write_view(0, 0, 40, -201326592, 0, 805306368);
      send_pixel(0, 0);
      send_pixel(1, 1);
      send_pixel(4095, 0);
      write_view(1, 1, 0, 0, 0, 805306368);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      write_view(4096, 4096, 1, 32'h7fffffff, 32'h80000000, 31'h7fffffff);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(2048, 0);
      write_view(8191, 8191, 300, 32'h80000000, 32'h7fffffff, 31'h7fffffff);
      send_pixel(0, 4095);
      send_pixel(4095, 0);
      write_view(64, 64, 500, -201326592, 30000000, 600000000);
      for (int k = 0; k < 6; k++) send_pixel($urandom_range(63), $urandom_range(63));
      // never escapes: full count at the widest limit
      write_view(16, 16, 65535, 0, 0, 0);
      send_pixel(5, 7);
   endtask

   task automatic rand_view(bit wild);
      int unsigned w, h;
      if (wild)
         write_view($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 400),
                    longint'($signed($urandom())), longint'($signed($urandom())),
                    $urandom() & 31'h7fffffff);
      else begin
         w = $urandom_range(1, 4096);
         h = $urandom_range(1, 4096);
         write_view(w, h, $urandom_range(1, 120),
                    longint'($urandom_range(0, 671088640)) - 536870912,
                    longint'($urandom_range(0, 536870912)) - 268435456,
                    $urandom_range(1 << 16, 805306368));
      end
   endtask

   task automatic test_random_pixels(int s_idle, int r_idle);
      int unsigned w, h;
      send_idle = s_idle;
      recv_idle = r_idle;
      for (int ph = 0; ph < 3; ph++) begin
         rand_view(ph == 2);
         w = (view_width == 0) ? 1 : (view_width > 4096 ? 4096 : view_width);
         h = (view_height == 0) ? 1 : (view_height > 4096 ? 4096 : view_height);
         for (int k = 0; k < 160; k++) begin
            if (k == 80 && ph == 1) drain_pixels();
            if ($urandom_range(9) == 0) send_pixel($urandom() & 12'hfff, $urandom() & 12'hfff);
            else send_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1));
         end
      end
   endtask

   initial begin
      req_if.valid   <= 1'b0;
      req_if.pixel_x <= '0;
      req_if.pixel_y <= '0;
      view_width = 640; view_height = 480; iter_limit = 256;
      view_cre = -201326592; view_cim = 0; view_span = 805306368;
      build_color_ramp();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_view();
      test_edge_views();
      test_random_pixels(31, 59);
      test_random_pixels(59, 31);
      test_random_pixels(0, 0);
      drain_pixels();
      repeat (20) @(posedge clock);
      $display("Covered %0d pixels (%0d checked, %0d inside the set) over reset, edge and",
               pixels_sent, pixels_seen, dark_pixels);
      $display("random views with sender and receiver stalls.");
      if (error_count == 0 && expected_pixels.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #80ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### files.f
design/mbe_pkg.sv
design/mbe_ifs.sv
design/mbe_div.sv
design/mbe_front.sv
design/mbe_queue.sv
design/mbe_back.sv
design/mandelbrot_escape_time_pixel_core.sv
verif/tb.sv
